// ===== design/adjacency_matrix_graph_store_unit_assert.svh =====
// Assertion macros used by the checker of the graph store.
`ifndef ADJACENCY_MATRIX_GRAPH_STORE_UNIT_ASSERT_SVH
`define ADJACENCY_MATRIX_GRAPH_STORE_UNIT_ASSERT_SVH

`define AMGS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("graph store check failed");

`define AMGS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("graph store check failed");

`endif

// ===== design/amgs_pkg.sv =====
`default_nettype none
package amgs_pkg;

  localparam int OP_W   = 4;
  localparam int NODE_W = 4;
  localparam int NUM_W  = 5;
  localparam int STAT_W = 2;

  localparam logic [OP_W-1:0] OP_CLEAR    = 4'd0;
  localparam logic [OP_W-1:0] OP_ADD_EDGE = 4'd1;
  localparam logic [OP_W-1:0] OP_NEIGH    = 4'd2;
  localparam logic [OP_W-1:0] OP_DEGREE   = 4'd3;
  localparam logic [OP_W-1:0] OP_MIN_DEG  = 4'd4;
  localparam logic [OP_W-1:0] OP_PROPS    = 4'd5;
  localparam logic [OP_W-1:0] OP_COMPLETE = 4'd6;
  localparam logic [OP_W-1:0] OP_PATH     = 4'd7;
  localparam logic [OP_W-1:0] OP_CYCLE    = 4'd8;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [STAT_W-1:0] ST_CYC_MIN  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } req_t;

  typedef struct packed {
    logic [NUM_W-1:0]  result_value;
    logic              value_valid;
    logic              null_flag;
    logic              trivial_flag;
    logic              simple_flag;
    logic [STAT_W-1:0] status;
    logic              last;
  } res_t;

endpackage
`default_nettype wire

// ===== design/amgs_if.sv =====
`default_nettype none
interface amgs_req_if;
  logic           valid;
  logic           ready;
  amgs_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface amgs_res_if;
  logic           valid;
  logic           ready;
  amgs_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface amgs_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [amgs_pkg::NUM_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/adjacency_matrix_graph_store_unit.sv =====
// Channel   Role    Carries
// cfg_i     sink    num_nodes write
// req_i     sink    operation, node_a, node_b
// res_o     source  result fields with last
// A request is taken only when the unit is idle; one is worked on at a time.
// Add edge reads and writes the row of each end node in turn, neighbours scans the
// columns up to the last neighbour and gives one result per neighbour, minimum degree
// and properties read every row in turn, and the patterns write one row per vertex.
// Reset clears the per-row valid flags at once, so no clearing pass is needed.
// A result waiting in the output register stalls the unit at its next result until it is taken.
`default_nettype none
module adjacency_matrix_graph_store_unit #(
  parameter int MAX_NODES   = 16,
  parameter int COUNT_WIDTH = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  amgs_cfg_if.sink    cfg_i,
  amgs_req_if.sink    req_i,
  amgs_res_if.source  res_o
);
  import amgs_pkg::*;

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int RW = MAX_NODES * COUNT_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_PUSH  = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [NUM_W-1:0]     num_q;
  logic [NUM_W-1:0]     n;
  logic [OP_W-1:0]      op_q, op_d;
  logic [NODE_W-1:0]    a_q, a_d, b_q, b_d;
  logic [NUM_W-1:0]     cnt_q, cnt_d, cnt_inc;
  logic                 phase_q, phase_d;
  logic [NUM_W-1:0]     acc_q, acc_d;
  logic [MAX_NODES-1:0] mask_q, mask_d;
  res_t                 res_q, res_d;
  res_t                 out_q;
  logic                 out_valid_q;
  logic                 out_load;

  logic [RW-1:0]        mem_q [MAX_NODES];
  logic [MAX_NODES-1:0] vld_q;
  logic [RW-1:0]        rd_q;
  logic                 rowv_q;
  logic                 re, we, vclr;
  logic [AW-1:0]        raddr, waddr;
  logic [RW-1:0]        wdata;

  logic [RW-1:0]        row_eff, row_mod, row_pat;
  logic [MAX_NODES-1:0] nz, ge2;
  logic [NUM_W-1:0]     pc;
  logic [AW-1:0]        col;
  logic [COUNT_WIDTH-1:0] old_cnt;

  function automatic logic [NUM_W-1:0] pop(input logic [MAX_NODES-1:0] v);
    logic [NUM_W-1:0] c;
    c = '0;
    for (int k = 0; k < MAX_NODES; k++) begin
      c = c + NUM_W'(v[k]);
    end
    return c;
  endfunction

  assign n = (32'(num_q) > MAX_NODES) ? NUM_W'(MAX_NODES) : num_q;
  assign cnt_inc = cnt_q + NUM_W'(1);

  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= '0;
    end else if (cfg_i.valid) begin
      num_q <= cfg_i.data;
    end
  end

  assign row_eff = rowv_q ? rd_q : '0;

  always_comb begin
    for (int j = 0; j < MAX_NODES; j++) begin
      nz[j]  = (row_eff[j*COUNT_WIDTH +: COUNT_WIDTH] != '0) && (j < int'(n));
      ge2[j] = (row_eff[j*COUNT_WIDTH +: COUNT_WIDTH] > COUNT_WIDTH'(1))
               && (j < int'(n)) && (j >= int'(cnt_q));
    end
  end
  assign pc = pop(nz);

  assign col     = phase_q ? AW'(a_q) : AW'(b_q);
  assign old_cnt = row_eff[col*COUNT_WIDTH +: COUNT_WIDTH];
  always_comb begin
    row_mod = row_eff;
    if (old_cnt != CNT_MAX) begin
      row_mod[col*COUNT_WIDTH +: COUNT_WIDTH] = old_cnt + COUNT_WIDTH'(1);
    end
  end

  always_comb begin
    int r;
    int nn;
    logic bit_set;
    r  = int'(cnt_q);
    nn = int'(n);
    row_pat = '0;
    for (int j = 0; j < MAX_NODES; j++) begin
      bit_set = 1'b0;
      if (op_q == OP_COMPLETE) begin
        bit_set = (j < nn) && (j != r);
      end else begin
        bit_set = (j < nn) && ((j == r + 1) || (r == j + 1));
        if (op_q == OP_CYCLE) begin
          bit_set = bit_set || ((r == 0) && (j == nn - 1)) || ((j == 0) && (r == nn - 1));
        end
      end
      row_pat[j*COUNT_WIDTH +: COUNT_WIDTH] = COUNT_WIDTH'(bit_set);
    end
  end

  always_comb begin
    priority if (op_q == OP_ADD_EDGE) begin
      raddr = phase_q ? AW'(b_q) : AW'(a_q);
    end else if (op_q == OP_NEIGH || op_q == OP_DEGREE) begin
      raddr = AW'(a_q);
    end else begin
      raddr = AW'(cnt_q);
    end
  end

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    a_d      = a_q;
    b_d      = b_q;
    cnt_d    = cnt_q;
    phase_d  = phase_q;
    acc_d    = acc_q;
    mask_d   = mask_q;
    res_d    = res_q;
    re       = 1'b0;
    we       = 1'b0;
    vclr     = 1'b0;
    waddr    = phase_q ? AW'(b_q) : AW'(a_q);
    wdata    = row_mod;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d    = req_i.data.operation;
          a_d     = req_i.data.node_a;
          b_d     = req_i.data.node_b;
          res_d   = '0;
          res_d.last = 1'b1;
          cnt_d   = '0;
          phase_d = 1'b0;
          state_d = S_PUSH;
          case (req_i.data.operation)
            OP_CLEAR: vclr = 1'b1;
            OP_ADD_EDGE: begin
              if ({1'b0, req_i.data.node_a} >= n || {1'b0, req_i.data.node_b} >= n) begin
                res_d.status = ST_RANGE;
              end else begin
                state_d = S_READ;
              end
            end
            OP_NEIGH, OP_DEGREE: begin
              if ({1'b0, req_i.data.node_a} >= n) begin
                res_d.status = ST_RANGE;
              end else begin
                state_d = S_READ;
              end
            end
            OP_MIN_DEG: begin
              acc_d = '1;
              if (n != '0) begin
                state_d = S_READ;
              end
            end
            OP_PROPS: begin
              res_d.simple_flag = 1'b1;
              res_d.null_flag   = (n == '0);
              if (n != '0) begin
                state_d = S_READ;
              end
            end
            OP_COMPLETE, OP_PATH: begin
              vclr = 1'b1;
              if (n != '0) begin
                state_d = S_WRITE;
              end
            end
            OP_CYCLE: begin
              if (n < NUM_W'(3)) begin
                res_d.status = ST_CYC_MIN;
              end else begin
                vclr    = 1'b1;
                state_d = S_WRITE;
              end
            end
            default: state_d = S_PUSH;
          endcase
        end
      end
      S_READ: begin
        re      = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        state_d = S_PUSH;
        case (op_q)
          OP_ADD_EDGE: begin
            we = 1'b1;
            if (!phase_q) begin
              phase_d = 1'b1;
              state_d = S_READ;
            end
          end
          OP_NEIGH: begin
            mask_d = nz;
            cnt_d  = '0;
            if (nz != '0) begin
              state_d = S_SCAN;
            end
          end
          OP_DEGREE: begin
            res_d.result_value = pc;
            res_d.value_valid  = 1'b1;
          end
          OP_MIN_DEG: begin
            if (pc < acc_q) begin
              acc_d = pc;
            end
            if (cnt_inc == n) begin
              res_d.result_value = (pc < acc_q) ? pc : acc_q;
              res_d.value_valid  = 1'b1;
            end else begin
              cnt_d   = cnt_inc;
              state_d = S_READ;
            end
          end
          OP_PROPS: begin
            if (ge2 != '0) begin
              res_d.simple_flag = 1'b0;
            end
            if (cnt_q == '0 && n == NUM_W'(1) && row_eff[COUNT_WIDTH-1:0] == '0) begin
              res_d.trivial_flag = 1'b1;
            end
            if (cnt_inc != n) begin
              cnt_d   = cnt_inc;
              state_d = S_READ;
            end
          end
          default: state_d = S_PUSH;
        endcase
      end
      S_WRITE: begin
        we    = 1'b1;
        waddr = AW'(cnt_q);
        wdata = row_pat;
        if (cnt_inc == n) begin
          state_d = S_PUSH;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      S_SCAN: begin
        if (mask_q[AW'(cnt_q)]) begin
          res_d.result_value = cnt_q;
          res_d.value_valid  = 1'b1;
          res_d.last         = (((mask_q >> cnt_q) >> 1) == '0);
          state_d            = S_PUSH;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      S_PUSH: begin
        if (!out_valid_q || res_o.ready) begin
          out_load = 1'b1;
          if (op_q == OP_NEIGH && !res_q.last) begin
            cnt_d   = cnt_inc;
            state_d = S_SCAN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      rowv_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (vclr) begin
        vld_q <= '0;
      end
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (re) begin
        rowv_q <= vld_q[raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    a_q    <= a_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
    mask_q <= mask_d;
    res_q  <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem_q[raddr];
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

endmodule
`default_nettype wire

// ===== design/amgs_checker.sv =====
`default_nettype none
`include "adjacency_matrix_graph_store_unit_assert.svh"
module amgs_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           req_valid_i,
  input wire logic           req_ready_i,
  input wire logic           res_valid_i,
  input wire logic           res_ready_i,
  input wire amgs_pkg::res_t res_data_i
);
  import amgs_pkg::*;

  `AMGS_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(res_data_i))
  `AMGS_ASSERT_NEXT(a_busy_after_req, req_valid_i && req_ready_i, !req_ready_i)
  `AMGS_ASSERT_SAME(a_err_is_last, res_valid_i && res_data_i.status != ST_OK, res_data_i.last)
  `AMGS_ASSERT_SAME(a_props_last, res_valid_i && (res_data_i.null_flag || res_data_i.trivial_flag), res_data_i.last && !res_data_i.value_valid)

endmodule

bind adjacency_matrix_graph_store_unit amgs_checker u_amgs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);
`default_nettype wire

// ===== verif/adjacency_matrix_graph_store_unit_test.sv =====
`timescale 1ns / 1ps
`default_nettype none
module adjacency_matrix_graph_store_unit_test;
  import amgs_pkg::*;

  localparam int NODES = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef enum logic [1:0] {
    KIND_REQUEST,
    KIND_CONFIG,
    KIND_DRAIN
  } job_kind_e;

  typedef struct {
    job_kind_e        kind;
    req_t             request;
    logic [NUM_W-1:0] nodes;
  } job_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  amgs_cfg_if cfg_ch ();
  amgs_req_if req_ch ();
  amgs_res_if res_ch ();

  adjacency_matrix_graph_store_unit u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch.sink),
    .req_i (req_ch.sink),
    .res_o (res_ch.source)
  );

  always #1 clk_i = ~clk_i;

  job_t  pending_jobs[$];
  res_t  expected_results[$];
  logic [7:0] edge_count[NODES][NODES];
  logic [NUM_W-1:0] model_nodes;
  int    mismatches;
  int    idle_cycles;
  int    gap_left;
  int    burst_left;
  int    hold_left;
  int    long_hold_left;
  logic  stimulus_done;
  logic  fill_pressure;

  function automatic int active_count();
    return (model_nodes > NODES) ? NODES : int'(model_nodes);
  endfunction

  function automatic void wipe_graph();
    for (int i = 0; i < NODES; i++)
      for (int j = 0; j < NODES; j++)
        edge_count[i][j] = 8'd0;
  endfunction

  function automatic void join_nodes(int a, int b);
    if (edge_count[a][b] != 8'hFF) edge_count[a][b] = edge_count[a][b] + 8'd1;
    if (edge_count[b][a] != 8'hFF) edge_count[b][a] = edge_count[b][a] + 8'd1;
  endfunction

  function automatic int vertex_degree(int v, int n);
    int d;
    d = 0;
    for (int i = 0; i < n; i++)
      if (edge_count[v][i] != 0) d++;
    return d;
  endfunction

  function automatic res_t plain_result(logic [STAT_W-1:0] st);
    res_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void predict_graph(req_t rq);
    res_t r;
    int n;
    int a;
    int b;
    int best;
    int found;
    n = active_count();
    a = int'(rq.node_a);
    b = int'(rq.node_b);
    r = plain_result(ST_OK);
    case (rq.operation)
      OP_CLEAR: wipe_graph();
      OP_ADD_EDGE: begin
        if (a >= n || b >= n) r.status = ST_RANGE;
        else join_nodes(a, b);
      end
      OP_NEIGH: begin
        if (a >= n) begin
          r.status = ST_RANGE;
        end else begin
          found = 0;
          for (int i = 0; i < n; i++) begin
            if (edge_count[a][i] != 0) begin
              if (found > 0) expected_results.push_back(r);
              r = '0;
              r.result_value = NUM_W'(i);
              r.value_valid = 1'b1;
              found++;
            end
          end
          r.last = 1'b1;
        end
      end
      OP_DEGREE: begin
        if (a >= n) begin
          r.status = ST_RANGE;
        end else begin
          r.result_value = NUM_W'(vertex_degree(a, n));
          r.value_valid = 1'b1;
        end
      end
      OP_MIN_DEG: begin
        if (n > 0) begin
          best = vertex_degree(0, n);
          for (int i = 1; i < n; i++)
            if (vertex_degree(i, n) < best) best = vertex_degree(i, n);
          r.result_value = NUM_W'(best);
          r.value_valid = 1'b1;
        end
      end
      OP_PROPS: begin
        r.null_flag = (n == 0);
        r.trivial_flag = (n == 1 && edge_count[0][0] == 0);
        r.simple_flag = 1'b1;
        for (int i = 0; i < n; i++)
          for (int j = i; j < n; j++)
            if (edge_count[i][j] >= 2) r.simple_flag = 1'b0;
      end
      OP_COMPLETE: begin
        wipe_graph();
        for (int i = 0; i < n; i++)
          for (int j = i + 1; j < n; j++)
            join_nodes(i, j);
      end
      OP_PATH, OP_CYCLE: begin
        if (rq.operation == OP_CYCLE && n < 3) begin
          r.status = ST_CYC_MIN;
        end else begin
          wipe_graph();
          for (int i = 0; i + 1 < n; i++) join_nodes(i, i + 1);
          if (rq.operation == OP_CYCLE) join_nodes(0, n - 1);
        end
      end
      default: ;
    endcase
    expected_results.push_back(r);
  endfunction

  function automatic void queue_request(logic [OP_W-1:0] op, int a, int b);
    job_t j;
    j.kind = KIND_REQUEST;
    j.request.operation = op;
    j.request.node_a = NODE_W'(a);
    j.request.node_b = NODE_W'(b);
    j.nodes = '0;
    pending_jobs.push_back(j);
  endfunction

  function automatic void queue_control(job_kind_e kind, int value);
    job_t j;
    j.kind = kind;
    j.request = '0;
    j.nodes = NUM_W'(value);
    pending_jobs.push_back(j);
  endfunction

  function automatic logic [OP_W-1:0] OP_Complete_or_path();
    int k;
    k = $urandom_range(0, 2);
    return (k == 0) ? OP_COMPLETE : (k == 1) ? OP_PATH : OP_CYCLE;
  endfunction

  function automatic void queue_random_request(int n);
    int pick;
    int hi;
    hi = (n > 0) ? n - 1 : 0;
    pick = $urandom_range(0, 99);
    if (pick < 40)
      queue_request(OP_ADD_EDGE, $urandom_range(0, hi), $urandom_range(0, hi));
    else if (pick < 50)
      queue_request(OP_NEIGH, $urandom_range(0, hi), $urandom_range(0, 15));
    else if (pick < 58)
      queue_request(OP_DEGREE, $urandom_range(0, hi), $urandom_range(0, 15));
    else if (pick < 63)
      queue_request(OP_MIN_DEG, $urandom_range(0, 15), $urandom_range(0, 15));
    else if (pick < 68)
      queue_request(OP_PROPS, $urandom_range(0, 15), $urandom_range(0, 15));
    else if (pick < 73)
      queue_request(OP_Complete_or_path(), $urandom_range(0, 15), $urandom_range(0, 15));
    else if (pick < 76)
      queue_request(OP_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15));
    else
      queue_request(OP_W'($urandom_range(0, 15)), $urandom_range(0, 15),
                    $urandom_range(0, 15));
  endfunction

  initial begin
    int settings[$];
    settings = '{0, 1, 2, 3, 16, 31, 5, 16, 9};
    queue_request(OP_PROPS, 0, 0);
    queue_request(OP_MIN_DEG, 0, 0);
    queue_request(OP_ADD_EDGE, 0, 0);
    queue_request(OP_CYCLE, 0, 0);
    queue_control(KIND_CONFIG, 1);
    queue_request(OP_PROPS, 0, 0);
    queue_request(OP_ADD_EDGE, 0, 0);
    queue_request(OP_PROPS, 0, 0);
    queue_request(OP_NEIGH, 0, 0);
    queue_request(OP_DEGREE, 1, 0);
    queue_control(KIND_CONFIG, 16);
    queue_request(OP_COMPLETE, 0, 0);
    queue_request(OP_NEIGH, 15, 0);
    queue_request(OP_MIN_DEG, 0, 0);
    queue_request(OP_PATH, 0, 0);
    queue_request(OP_DEGREE, 15, 0);
    queue_request(OP_CYCLE, 0, 0);
    queue_request(OP_NEIGH, 0, 0);
    queue_request(OP_ADD_EDGE, 15, 0);
    queue_request(OP_PROPS, 0, 0);
    queue_request(OP_CLEAR, 0, 0);
    queue_request(OP_NEIGH, 3, 0);
    queue_request(OP_W'(9), 15, 15);
    queue_request(OP_W'(15), 0, 15);
    for (int k = 0; k < 130; k++) queue_request(OP_ADD_EDGE, 2, 2);
    queue_request(OP_PROPS, 0, 0);
    queue_request(OP_NEIGH, 2, 0);
    queue_control(KIND_DRAIN, 0);
    foreach (settings[s]) begin
      queue_control(KIND_CONFIG, settings[s]);
      for (int k = 0; k < 29; k++)
        queue_random_request((settings[s] > NODES) ? NODES : settings[s]);
      queue_control(KIND_DRAIN, 0);
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // The driver also keeps the predictor, so that a configuration write and
  // every request are modelled in the order in which the unit sees them.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
      cfg_ch.valid <= 1'b0;
      cfg_ch.data <= '0;
      gap_left <= 0;
      burst_left <= 0;
      stimulus_done <= 1'b0;
      model_nodes <= '0;
      wipe_graph();
    end else begin
      if (req_ch.valid && req_ch.ready) predict_graph(req_ch.data);
      if (cfg_ch.valid && cfg_ch.ready) model_nodes <= cfg_ch.data;
      if ((req_ch.valid && !req_ch.ready) || (cfg_ch.valid && !cfg_ch.ready)) begin
      end else if (gap_left > 0) begin
        req_ch.valid <= 1'b0;
        cfg_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_jobs.size() == 0) begin
        req_ch.valid <= 1'b0;
        cfg_ch.valid <= 1'b0;
        stimulus_done <= 1'b1;
      end else if (pending_jobs[0].kind != KIND_REQUEST &&
                   (req_ch.valid || cfg_ch.valid || expected_results.size() != 0)) begin
        req_ch.valid <= 1'b0;
        cfg_ch.valid <= 1'b0;
        gap_left <= 40;
      end else begin
        job_t j;
        j = pending_jobs.pop_front();
        req_ch.valid <= (j.kind == KIND_REQUEST);
        cfg_ch.valid <= (j.kind == KIND_CONFIG);
        if (j.kind == KIND_REQUEST) begin
          req_ch.data <= j.request;
        end else if (j.kind == KIND_CONFIG) begin
          cfg_ch.data <= j.nodes;
        end
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      hold_left <= 0;
      long_hold_left <= 600;
      fill_pressure <= 1'b0;
      idle_cycles <= 0;
      mismatches <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready && !fill_pressure) begin
        fill_pressure <= 1'b1;
      end
      if (fill_pressure && long_hold_left > 0) begin
        long_hold_left <= long_hold_left - 1;
        res_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if ($urandom_range(0, 9) < 3) hold_left <= $urandom_range(1, 8);
      end
      if (res_ch.valid && res_ch.ready) begin
        res_t exp_r;
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("Unexpected result %p", res_ch.data);
          mismatches <= mismatches + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (res_ch.data !== exp_r) begin
            if (mismatches < 10)
              $display("Mismatch: expected %p, actual %p", exp_r, res_ch.data);
            mismatches <= mismatches + 1;
          end
        end
      end
      if ((res_ch.valid && res_ch.ready) || (req_ch.valid && req_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (rst_ni);
    while (!(stimulus_done && expected_results.size() == 0) &&
           idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk_i);
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
    end else begin
      repeat (60) @(posedge clk_i);
      if (mismatches == 0 && expected_results.size() == 0)
        $display("Test completed successfully");
      else
        $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== adjacency_matrix_graph_store_unit.f =====
+incdir+design
design/amgs_pkg.sv
design/amgs_if.sv
design/adjacency_matrix_graph_store_unit.sv
design/amgs_checker.sv
verif/adjacency_matrix_graph_store_unit_test.sv
